// ===== rtl/qcsa_pkg.sv =====
// ----------------------------------------------------------------------------
// qcsa_pkg
// Shared types and constants of the quartet column score accumulator.
// ----------------------------------------------------------------------------
`default_nettype none

package qcsa_pkg;

   localparam int CHAR_BITS_DEFAULT        = 7;
   localparam int TABLE_VALUE_BITS_DEFAULT = 8;
   localparam int SCORE_BITS_DEFAULT       = 40;

   // Gap character of the alignment, ASCII '-'
   localparam logic [7:0] GAP_CHAR = 8'd45;

   localparam int ALPHA_BITS    = 10;
   localparam int BASE_BITS     = 8;
   localparam int CSR_DATA_BITS = 10;
   localparam int CSR_INDEX_BITS = 2;

   // Output queue depth; bounds the results in flight
   localparam int RESULT_DEPTH = 4;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_SCORE_MODE   = 2'd0,
      REG_GAP_MODE     = 2'd1,
      REG_ALPHA_WEIGHT = 2'd2,
      REG_BASE_SCORE   = 2'd3
   } reg_index_type;

   typedef enum logic {
      CMD_COLUMN      = 1'b0,
      CMD_TABLE_WRITE = 1'b1
   } command_type;

   typedef enum logic {
      MODE_NUCLEOTIDE = 1'b0,
      MODE_PROTEIN    = 1'b1
   } score_mode_type;

   localparam logic [1:0] GAP_KEEP_ALL = 2'd0;
   localparam logic [1:0] GAP_SKIP_TWO = 2'd1;
   localparam logic [1:0] GAP_SKIP_ANY = 2'd2;

   typedef enum logic [1:0] {
      NUC_NONE   = 2'd0,
      NUC_SINGLE = 2'd1,
      NUC_DOUBLE = 2'd2
   } nuc_class_type;

   // Table read sequencer: cross entries of the first character, cross
   // entries of the second character, then the two pair entries
   typedef enum logic [1:0] {
      PH_IDLE    = 2'd0,
      PH_CROSS_B = 2'd1,
      PH_PAIRS   = 2'd2
   } phase_type;

   typedef struct packed {
      logic          skip;
      logic          last;
      nuc_class_type nuc;
   } col_ctrl_type;

endpackage

`default_nettype wire

// ===== rtl/quartet_column_score_accumulator_core.sv =====
// ----------------------------------------------------------------------------
// quartet_column_score_accumulator_core
// Scores alignment columns of one quartet and emits the saturated total.
// ----------------------------------------------------------------------------
// Usage:
//   req channel: one transfer is one item. req_tuser is the command: a column
//   to score, or a write of one substitution table entry. req_tlast marks the
//   last column of a quartet; that column emits the total on rsp and clears it.
//   csr channel: register writes (score mode, gap mode, alpha, base score),
//   always ready, one per cycle; write only while the block is idle.
//   Throughput: a column blocks new items while the sequencer makes the six table
//   reads over the two read ports of the table memory; table writes are taken
//   one per cycle while req_tready is high.
//   Up to RESULT_DEPTH totals queue in the output buffer; when the receiver
//   stalls, req_tready drops once that many totals are pending, and columns
//   already in flight complete into the buffer.
//   Reset clears the registers to their defaults, the total and the output
//   queue. The table is not cleared: an entry must be written before a
//   protein column reads it.
// ----------------------------------------------------------------------------
`default_nettype none

module quartet_column_score_accumulator_core #(
   parameter int CHAR_BITS        = qcsa_pkg::CHAR_BITS_DEFAULT,
   parameter int TABLE_VALUE_BITS = qcsa_pkg::TABLE_VALUE_BITS_DEFAULT,
   parameter int SCORE_BITS       = qcsa_pkg::SCORE_BITS_DEFAULT,
   localparam int IN_FIELD_BITS   = 6 * CHAR_BITS + TABLE_VALUE_BITS,
   localparam int IN_DATA_BITS    = ((IN_FIELD_BITS + 7) / 8) * 8,
   localparam int OUT_DATA_BITS   = ((SCORE_BITS + 7) / 8) * 8
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   output logic                                      req_tready,
   // left_first, left_second, right_first, right_second, table_row,
   // table_col, table_value
   input  wire logic [IN_DATA_BITS-1:0]              req_tdata,
   // command
   input  wire logic                                 req_tuser,
   input  wire logic                                 req_tlast,
   output logic                                      rsp_tvalid,
   input  wire logic                                 rsp_tready,
   // quartet_score
   output logic [OUT_DATA_BITS-1:0]                  rsp_tdata,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic [qcsa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [qcsa_pkg::CSR_DATA_BITS-1:0]   csr_data
);
   import qcsa_pkg::*;

   localparam int CB         = CHAR_BITS;
   localparam int TV         = TABLE_VALUE_BITS;
   localparam int ADDR_BITS  = 2 * CB;
   localparam int DEPTH      = 1 << ADDR_BITS;
   localparam int PRICE_BITS = TV + 1;
   localparam int PROT_BITS  = PRICE_BITS + ALPHA_BITS;
   localparam int NUC_BITS   = 1 + BASE_BITS + ALPHA_BITS;
   localparam int ADD_BITS   = (PROT_BITS > NUC_BITS) ? PROT_BITS : NUC_BITS;
   localparam int SUM_BITS   = ((SCORE_BITS > ADD_BITS) ? SCORE_BITS : ADD_BITS) + 1;
   localparam int PTR_BITS   = $clog2(RESULT_DEPTH);
   localparam int CNT_BITS   = $clog2(RESULT_DEPTH + 1);

   // ---------------- configuration registers ----------------
   score_mode_type          score_mode_ff;
   logic [1:0]              gap_mode_ff;
   logic [ALPHA_BITS-1:0]   alpha_ff;
   logic [BASE_BITS-1:0]    base_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         score_mode_ff <= MODE_NUCLEOTIDE;
         gap_mode_ff   <= GAP_KEEP_ALL;
         alpha_ff      <= ALPHA_BITS'(1);
         base_ff       <= BASE_BITS'(1);
      end else if (csr_valid && csr_ready) begin
         unique case (reg_index_type'(csr_index))
            REG_SCORE_MODE:   score_mode_ff <= score_mode_type'(csr_data[0]);
            REG_GAP_MODE:     gap_mode_ff   <= csr_data[1:0];
            REG_ALPHA_WEIGHT: alpha_ff      <= csr_data[ALPHA_BITS-1:0];
            REG_BASE_SCORE:   base_ff       <= csr_data[BASE_BITS-1:0];
            default: ;
         endcase
      end
   end

   // ---------------- input unpacking ----------------
   logic [CB-1:0]        in_a, in_b, in_c, in_d, in_row, in_col;
   logic [TV-1:0]        in_value;

   assign in_a     = req_tdata[0*CB +: CB];
   assign in_b     = req_tdata[1*CB +: CB];
   assign in_c     = req_tdata[2*CB +: CB];
   assign in_d     = req_tdata[3*CB +: CB];
   assign in_row   = req_tdata[4*CB +: CB];
   assign in_col   = req_tdata[5*CB +: CB];
   assign in_value = req_tdata[6*CB +: TV];

   // ---------------- column classification at accept ----------------
   logic [2:0]     gap_count;
   logic           col_skip;
   nuc_class_type  col_nuc;

   always_comb begin
      gap_count = 3'(8'(in_a) == GAP_CHAR) + 3'(8'(in_b) == GAP_CHAR)
                + 3'(8'(in_c) == GAP_CHAR) + 3'(8'(in_d) == GAP_CHAR);
      case (gap_mode_ff)
         GAP_SKIP_TWO: col_skip = (gap_count >= 3'd2);
         GAP_SKIP_ANY: col_skip = (gap_count != 3'd0);
         default:      col_skip = 1'b0;
      endcase

      col_nuc = NUC_NONE;
      if (in_a == in_b) begin
         if (in_c == in_d) begin
            if (in_c != in_a) col_nuc = NUC_DOUBLE;
         end else if (in_a != in_c && in_a != in_d) begin
            col_nuc = NUC_SINGLE;
         end
      end else if (in_c == in_d && in_c != in_a && in_c != in_b) begin
         col_nuc = NUC_SINGLE;
      end
   end

   // ---------------- read sequencer ----------------
   phase_type      phase_ff, phase_in;
   logic [CNT_BITS-1:0] pending_ff;
   logic           in_xfer, col_xfer, tbl_xfer, rsp_xfer;
   logic [CB-1:0]  a_ff, b_ff, c_ff, d_ff;
   col_ctrl_type   s0_ctrl_ff;
   logic [ADDR_BITS-1:0] rd_addr_x, rd_addr_y;

   assign req_tready = (phase_ff == PH_IDLE) && (pending_ff < CNT_BITS'(RESULT_DEPTH));
   assign in_xfer    = req_tvalid && req_tready;
   assign col_xfer   = in_xfer && (command_type'(req_tuser) == CMD_COLUMN);
   assign tbl_xfer   = in_xfer && (command_type'(req_tuser) == CMD_TABLE_WRITE);
   assign rsp_xfer   = rsp_tvalid && rsp_tready;

   always_comb begin
      phase_in  = phase_ff;
      rd_addr_x = {in_a, in_c};
      rd_addr_y = {in_a, in_d};
      unique case (phase_ff)
         PH_IDLE: begin
            if (col_xfer) phase_in = PH_CROSS_B;
         end
         PH_CROSS_B: begin
            rd_addr_x = {b_ff, c_ff};
            rd_addr_y = {b_ff, d_ff};
            phase_in  = PH_PAIRS;
         end
         PH_PAIRS: begin
            rd_addr_x = {a_ff, b_ff};
            rd_addr_y = {c_ff, d_ff};
            phase_in  = PH_IDLE;
         end
         default: phase_in = PH_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) phase_ff <= PH_IDLE;
      else       phase_ff <= phase_in;
   end

   always_ff @(posedge clock) begin
      if (col_xfer) begin
         a_ff       <= in_a;
         b_ff       <= in_b;
         c_ff       <= in_c;
         d_ff       <= in_d;
         s0_ctrl_ff <= '{skip: col_skip, last: req_tlast, nuc: col_nuc};
      end
   end

   // Totals not yet taken by the receiver, counted from the column transfer
   always_ff @(posedge clock) begin
      if (reset) begin
         pending_ff <= '0;
      end else begin
         pending_ff <= pending_ff + CNT_BITS'(col_xfer && req_tlast)
                                  - CNT_BITS'(rsp_xfer);
      end
   end

   // ---------------- substitution table ----------------
   logic signed [TV-1:0] table_mem [DEPTH];
   logic signed [TV-1:0] rd_x_ff, rd_y_ff;

   always_ff @(posedge clock) begin
      if (tbl_xfer) table_mem[{in_row, in_col}] <= in_value;
      rd_x_ff <= table_mem[rd_addr_x];
      rd_y_ff <= table_mem[rd_addr_y];
   end

   // ---------------- penalty and prices ----------------
   logic signed [TV-1:0]         pen_ff, max_xy, max_pxy;
   logic signed [PRICE_BITS-1:0] p1_in, p2_in, p1_ff, p2_ff;
   logic                         s1_valid_ff, s2_valid_ff, s3_valid_ff;
   col_ctrl_type                 s1_ctrl_ff, s2_ctrl_ff;
   logic                         s3_last_ff;

   always_comb begin
      max_xy  = (rd_y_ff > rd_x_ff) ? rd_y_ff : rd_x_ff;
      max_pxy = (max_xy > pen_ff) ? max_xy : pen_ff;
      p1_in   = PRICE_BITS'(rd_x_ff) - PRICE_BITS'(pen_ff);
      p2_in   = PRICE_BITS'(rd_y_ff) - PRICE_BITS'(pen_ff);
   end

   always_ff @(posedge clock) begin
      unique case (phase_ff)
         PH_CROSS_B: pen_ff <= max_xy;
         PH_PAIRS:   pen_ff <= max_pxy;
         default: ;
      endcase
      if (phase_ff == PH_PAIRS) s1_ctrl_ff <= s0_ctrl_ff;
      if (s1_valid_ff) begin
         p1_ff      <= p1_in;
         p2_ff      <= p2_in;
         s2_ctrl_ff <= s1_ctrl_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= (phase_ff == PH_PAIRS);
         s2_valid_ff <= s1_valid_ff;
         s3_valid_ff <= s2_valid_ff;
      end
   end

   // ---------------- column score ----------------
   logic                  pos1, pos2;
   logic [PRICE_BITS-1:0] price_sum;
   logic [PROT_BITS-1:0]  prot_prod;
   logic [NUC_BITS-2:0]   nuc_prod;
   logic [ADD_BITS-1:0]   add_in, add_ff;

   always_comb begin
      pos1      = !p1_ff[PRICE_BITS-1] && (p1_ff != '0);
      pos2      = !p2_ff[PRICE_BITS-1] && (p2_ff != '0);
      price_sum = p1_ff + p2_ff;
      prot_prod = PROT_BITS'(price_sum) * PROT_BITS'(alpha_ff);
      nuc_prod  = (NUC_BITS-1)'(base_ff) * (NUC_BITS-1)'(alpha_ff);
      add_in    = '0;
      if (!s2_ctrl_ff.skip) begin
         if (score_mode_ff == MODE_PROTEIN) begin
            if (pos1 && pos2) add_in = ADD_BITS'(prot_prod);
            else if (pos1)    add_in = ADD_BITS'(p1_ff);
            else if (pos2)    add_in = ADD_BITS'(p2_ff);
         end else begin
            case (s2_ctrl_ff.nuc)
               NUC_DOUBLE: add_in = ADD_BITS'({nuc_prod, 1'b0});
               NUC_SINGLE: add_in = ADD_BITS'(base_ff);
               default:    add_in = '0;
            endcase
         end
      end
   end

   always_ff @(posedge clock) begin
      if (s2_valid_ff) begin
         add_ff     <= add_in;
         s3_last_ff <= s2_ctrl_ff.last;
      end
   end

   // ---------------- saturating accumulate ----------------
   logic [SCORE_BITS-1:0] acc_ff, acc_sat;
   logic [SUM_BITS-1:0]   acc_sum;

   always_comb begin
      acc_sum = SUM_BITS'(acc_ff) + SUM_BITS'(add_ff);
      if (acc_sum[SUM_BITS-1:SCORE_BITS] != '0) acc_sat = '1;
      else                                      acc_sat = acc_sum[SCORE_BITS-1:0];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff <= '0;
      end else if (s3_valid_ff) begin
         acc_ff <= s3_last_ff ? '0 : acc_sat;
      end
   end

   // ---------------- result queue ----------------
   logic [SCORE_BITS-1:0] res_mem_ff [RESULT_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff, rd_ptr_ff;
   logic [CNT_BITS-1:0]   res_count_ff;
   logic                  push;

   assign push = s3_valid_ff && s3_last_ff;

   always_ff @(posedge clock) begin
      if (push) res_mem_ff[wr_ptr_ff] <= acc_sat;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff    <= '0;
         rd_ptr_ff    <= '0;
         res_count_ff <= '0;
      end else begin
         if (push)     wr_ptr_ff <= wr_ptr_ff + PTR_BITS'(1);
         if (rsp_xfer) rd_ptr_ff <= rd_ptr_ff + PTR_BITS'(1);
         res_count_ff <= res_count_ff + CNT_BITS'(push) - CNT_BITS'(rsp_xfer);
      end
   end

   assign rsp_tvalid = (res_count_ff != '0);
   assign rsp_tdata  = OUT_DATA_BITS'(res_mem_ff[rd_ptr_ff]);

endmodule

`default_nettype wire

// ===== sim/qcsa_checker.sv =====
// ----------------------------------------------------------------------------
// qcsa_checker
// Watches the req, rsp and csr channels of the quartet column score
// accumulator, predicts every quartet total from the accepted columns and
// table writes, and compares each total that leaves the block in order.
// ----------------------------------------------------------------------------
module qcsa_checker #(
   parameter int IN_W  = 56,
   parameter int OUT_W = 40
) (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_tvalid,
   input  wire logic                                 req_tready,
   input  wire logic [IN_W-1:0]                      req_tdata,
   input  wire logic                                 req_tuser,
   input  wire logic                                 req_tlast,
   input  wire logic                                 rsp_tvalid,
   input  wire logic                                 rsp_tready,
   input  wire logic [OUT_W-1:0]                     rsp_tdata,
   input  wire logic                                 csr_valid,
   input  wire logic                                 csr_ready,
   input  wire logic [qcsa_pkg::CSR_INDEX_BITS-1:0]  csr_index,
   input  wire logic [qcsa_pkg::CSR_DATA_BITS-1:0]   csr_data,
   input  wire logic                                 finish_check,
   output int                                        fail_count,
   output int                                        outstanding,
   output int                                        totals_checked
);
   timeunit 1ns;
   timeprecision 1ps;
   import qcsa_pkg::*;

   localparam int CW  = CHAR_BITS_DEFAULT;
   localparam int TVW = TABLE_VALUE_BITS_DEFAULT;
   localparam int SW  = SCORE_BITS_DEFAULT;

   typedef logic [CW-1:0] char_type;

   localparam logic [SW-1:0] TOTAL_CEILING = '1;
   localparam char_type      GAP           = GAP_CHAR[CW-1:0];

   score_mode_type        cur_mode;
   logic [1:0]            cur_gap;
   logic [ALPHA_BITS-1:0] cur_alpha;
   logic [BASE_BITS-1:0]  cur_base;

   logic [SW-1:0]         running_total;
   logic [SW-1:0]         expected_totals[$];
   logic signed [TVW-1:0] subst_table [0:(1 << (2 * CW)) - 1];

   int mismatch_total = 0;
   int compared       = 0;
   bit leftover_done  = 1'b0;

   assign fail_count     = mismatch_total;
   assign totals_checked = compared;

   task automatic report_mismatch(input string what);
      $display("[%0t] MISMATCH: %s", $time, what);
      mismatch_total++;
   endtask

   function automatic logic column_dropped(input char_type a, b, c, d);
      int gaps;
      gaps = int'(a == GAP) + int'(b == GAP) + int'(c == GAP) + int'(d == GAP);
      case (cur_gap)
         GAP_SKIP_TWO: return gaps >= 2;
         GAP_SKIP_ANY: return gaps >= 1;
         default:      return 1'b0;
      endcase
   endfunction

   function automatic logic [SW-1:0] nucleotide_gain(input char_type a, b, c, d);
      logic [SW-1:0] unit, doubled;
      unit    = SW'(cur_base);
      doubled = SW'(cur_base) * SW'(cur_alpha) * SW'(2);
      if (a == b) begin
         if (c == d) begin
            if (c != a) return doubled;
         end else if (a != c && a != d) begin
            return unit;
         end
      end else if (c == d && c != a && c != b) begin
         return unit;
      end
      return '0;
   endfunction

   function automatic int table_at(input char_type row, input char_type col);
      return int'(subst_table[{row, col}]);
   endfunction

   // Penalty is the strongest cross-pair substitution; each pair pays it
   function automatic logic [SW-1:0] protein_gain(input char_type a, b, c, d);
      int penalty, left_price, right_price;
      penalty = table_at(a, c);
      if (table_at(a, d) > penalty) penalty = table_at(a, d);
      if (table_at(b, c) > penalty) penalty = table_at(b, c);
      if (table_at(b, d) > penalty) penalty = table_at(b, d);
      left_price  = table_at(a, b) - penalty;
      right_price = table_at(c, d) - penalty;
      if (left_price > 0 && right_price > 0)
         return SW'(left_price + right_price) * SW'(cur_alpha);
      if (left_price > 0) return SW'(left_price);
      if (right_price > 0) return SW'(right_price);
      return '0;
   endfunction

   always @(posedge clock) begin : monitor
      char_type      a, b, c, d;
      logic [SW-1:0] gain, want, got;
      if (reset) begin
         cur_mode      = MODE_NUCLEOTIDE;
         cur_gap       = GAP_KEEP_ALL;
         cur_alpha     = 1;
         cur_base      = 1;
         running_total = '0;
         expected_totals.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            case (reg_index_type'(csr_index))
               REG_SCORE_MODE:   cur_mode  = score_mode_type'(csr_data[0]);
               REG_GAP_MODE:     cur_gap   = csr_data[1:0];
               REG_ALPHA_WEIGHT: cur_alpha = csr_data[ALPHA_BITS-1:0];
               REG_BASE_SCORE:   cur_base  = csr_data[BASE_BITS-1:0];
               default: ;
            endcase
         end

         if (req_tvalid && req_tready) begin
            a = req_tdata[0*CW +: CW];
            b = req_tdata[1*CW +: CW];
            c = req_tdata[2*CW +: CW];
            d = req_tdata[3*CW +: CW];
            if (command_type'(req_tuser) == CMD_TABLE_WRITE) begin
               subst_table[{req_tdata[4*CW +: CW], req_tdata[5*CW +: CW]}] =
                  req_tdata[6*CW +: TVW];
            end else begin
               if (!column_dropped(a, b, c, d)) begin
                  gain = (cur_mode == MODE_PROTEIN) ? protein_gain(a, b, c, d)
                                                    : nucleotide_gain(a, b, c, d);
                  if (gain > TOTAL_CEILING - running_total)
                     running_total = TOTAL_CEILING;
                  else
                     running_total += gain;
               end
               if (req_tlast) begin
                  expected_totals.push_back(running_total);
                  running_total = '0;
               end
            end
         end

         if (rsp_tvalid && rsp_tready) begin
            got = rsp_tdata[SW-1:0];
            if (expected_totals.size() == 0) begin
               report_mismatch($sformatf("quartet total %0d arrived with none expected", got));
            end else begin
               want = expected_totals.pop_front();
               compared++;
               if (got !== want)
                  report_mismatch($sformatf("quartet_score %0d, expected %0d", got, want));
            end
         end

         if (finish_check && !leftover_done) begin
            leftover_done = 1'b1;
            if (expected_totals.size() != 0)
               report_mismatch($sformatf("%0d quartet totals never arrived",
                                         expected_totals.size()));
         end
      end
      outstanding <= expected_totals.size();
   end

endmodule

// ===== sim/tb_top.sv =====
// ----------------------------------------------------------------------------
// tb_top
// Stimulus for the quartet column score accumulator: directed columns for the
// scoring rules and gap modes, a substitution table load, then random phases
// of quartets under changing register settings with bursty input and a
// stalling receiver. The checker beside the block judges every total.
// ----------------------------------------------------------------------------
module tb_top;
   timeunit 1ns;
   timeprecision 1ps;
   import qcsa_pkg::*;

   localparam int CW           = CHAR_BITS_DEFAULT;
   localparam int TVW          = TABLE_VALUE_BITS_DEFAULT;
   localparam int IN_W         = ((6 * CW + TVW + 7) / 8) * 8;
   localparam int OUT_W        = ((SCORE_BITS_DEFAULT + 7) / 8) * 8;
   localparam int RANDOM_ITEMS = 1700;
   localparam int SETTLE_CYCLES = 10;
   localparam int LONG_HOLD     = 300;

   localparam logic [1:0] GAP_UNUSED = 2'd3;

   typedef logic [CW-1:0] char_type;

   localparam char_type GAP  = GAP_CHAR[CW-1:0];
   localparam char_type CH_A = 7'd65;
   localparam char_type CH_C = 7'd67;
   localparam char_type CH_G = 7'd71;
   localparam char_type CH_T = 7'd84;
   localparam char_type CH_LO = 7'd0;
   localparam char_type CH_HI = 7'd127;

   logic                      clock      = 1'b0;
   logic                      reset      = 1'b1;
   logic                      req_tvalid = 1'b0;
   logic                      req_tready;
   logic [IN_W-1:0]           req_tdata  = '0;
   logic                      req_tuser  = 1'b0;
   logic                      req_tlast  = 1'b0;
   logic                      rsp_tvalid;
   logic                      rsp_tready = 1'b0;
   logic [OUT_W-1:0]          rsp_tdata;
   logic                      csr_valid  = 1'b0;
   logic                      csr_ready;
   logic [CSR_INDEX_BITS-1:0] csr_index  = '0;
   logic [CSR_DATA_BITS-1:0]  csr_data   = '0;
   logic                      finish_check = 1'b0;

   int fail_count, outstanding, totals_checked;

   char_type dna_chars[5]      = '{CH_A, CH_C, CH_G, CH_T, GAP};
   // every pair of these has a table entry once the load is done
   char_type protein_chars[10] = '{CH_LO, CH_HI, GAP, CH_A, CH_C, CH_G, CH_T,
                                   7'd87, 7'd89, 7'd75};

   int items_sent    = 0;
   int columns_sent  = 0;
   int writes_sent   = 0;
   int settings_used = 0;
   int burst_left    = 0;
   int hold_requests = 0;
   bit steady_sender = 1'b0;

   always #5 clock = ~clock;

   quartet_column_score_accumulator_core DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   qcsa_checker #(.IN_W(IN_W), .OUT_W(OUT_W)) u_check (
      .clock          (clock),
      .reset          (reset),
      .req_tvalid     (req_tvalid),
      .req_tready     (req_tready),
      .req_tdata      (req_tdata),
      .req_tuser      (req_tuser),
      .req_tlast      (req_tlast),
      .rsp_tvalid     (rsp_tvalid),
      .rsp_tready     (rsp_tready),
      .rsp_tdata      (rsp_tdata),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_index      (csr_index),
      .csr_data       (csr_data),
      .finish_check   (finish_check),
      .fail_count     (fail_count),
      .outstanding    (outstanding),
      .totals_checked (totals_checked)
   );

   // Receiver: changing stall patterns, plus a long hold-off on request
   always @(posedge clock) begin : rsp_side
      static int hold_left    = 0;
      static int hold_served  = 0;
      static int pattern      = 0;
      static int pattern_left = 0;
      if (hold_served != hold_requests) begin
         hold_served = hold_requests;
         hold_left   = LONG_HOLD;
      end
      if (hold_left > 0) begin
         hold_left--;
         rsp_tready <= 1'b0;
      end else begin
         if (pattern_left == 0) begin
            pattern      = $urandom_range(0, 3);
            pattern_left = $urandom_range(20, 150);
         end
         pattern_left--;
         case (pattern)
            0:       rsp_tready <= 1'b1;
            1:       rsp_tready <= ($urandom_range(0, 3) != 0);
            2:       rsp_tready <= ($urandom_range(0, 3) == 0);
            default: rsp_tready <= ~rsp_tready;
         endcase
      end
   end

   function automatic logic [IN_W-1:0] pack_item(input char_type a, b, c, d, row, col,
                                                 input logic [TVW-1:0] value);
      return IN_W'({value, col, row, d, c, b, a});
   endfunction

   task automatic offer_item(input command_type cmd, input logic [IN_W-1:0] data,
                             input logic last);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = (steady_sender || $urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_tvalid <= 1'b1;
      req_tdata  <= data;
      req_tuser  <= cmd;
      req_tlast  <= last;
      do @(posedge clock); while (!req_tready);
      items_sent++;
   endtask

   task automatic send_column(input char_type a, b, c, d, input logic last);
      offer_item(CMD_COLUMN,
                 pack_item(a, b, c, d, char_type'($urandom), char_type'($urandom),
                           TVW'($urandom)), last);
      columns_sent++;
   endtask

   task automatic send_table_write(input char_type row, col, input logic [TVW-1:0] value,
                                   input logic last);
      offer_item(CMD_TABLE_WRITE,
                 pack_item(char_type'($urandom), char_type'($urandom), char_type'($urandom),
                           char_type'($urandom), row, col, value), last);
      writes_sent++;
   endtask

   // Hold input until every total is back and the pipeline has emptied
   task automatic wait_idle();
      req_tvalid <= 1'b0;
      burst_left = 0;
      @(posedge clock);
      while (outstanding != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CSR_DATA_BITS-1:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= value;
      do @(posedge clock); while (!csr_ready);
   endtask

   task automatic write_config(input score_mode_type mode, input logic [1:0] gap_sel,
                               input logic [ALPHA_BITS-1:0] alpha,
                               input logic [BASE_BITS-1:0] base);
      wait_idle();
      write_reg(REG_SCORE_MODE, CSR_DATA_BITS'(mode));
      write_reg(REG_GAP_MODE, CSR_DATA_BITS'(gap_sel));
      write_reg(REG_ALPHA_WEIGHT, CSR_DATA_BITS'(alpha));
      write_reg(REG_BASE_SCORE, CSR_DATA_BITS'(base));
      csr_valid <= 1'b0;
      settings_used++;
   endtask

   function automatic char_type pick_char(input logic protein);
      if (protein) return protein_chars[$urandom_range(0, 9)];
      case ($urandom_range(0, 9))
         0, 1, 2, 3, 4: return dna_chars[$urandom_range(0, 4)];
         5, 6:          return protein_chars[$urandom_range(0, 9)];
         default:       return char_type'($urandom_range(0, 127));
      endcase
   endfunction

   // Bias toward equal pairs so the scoring branches are all exercised
   task automatic random_column(input logic protein, input logic last);
      char_type a, b, c, d;
      a = pick_char(protein);
      b = pick_char(protein);
      c = pick_char(protein);
      d = pick_char(protein);
      case ($urandom_range(0, 3))
         0: begin
            b = a;
            d = c;
         end
         1: b = a;
         2: d = c;
         default: ;
      endcase
      send_column(a, b, c, d, last);
   endtask

   task automatic random_table_write();
      if ($urandom_range(0, 1))
         send_table_write(protein_chars[$urandom_range(0, 9)],
                          protein_chars[$urandom_range(0, 9)],
                          TVW'($urandom), 1'($urandom));
      else
         send_table_write(char_type'($urandom), char_type'($urandom), TVW'($urandom),
                          1'($urandom));
   endtask

   initial begin : timeout
      #10ms;
      $display("DONE: errors detected");
      $finish;
   end

   initial begin : stimulus
      int                    target, phase_no, quartets, len;
      logic                  protein;
      logic [ALPHA_BITS-1:0] alpha;
      logic [BASE_BITS-1:0]  base;

      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Nucleotide rules at the largest weights
      write_config(MODE_NUCLEOTIDE, GAP_KEEP_ALL, '1, '1);
      send_column(CH_A, CH_A, CH_C, CH_C, 1'b0);
      send_column(CH_A, CH_A, CH_C, CH_G, 1'b0);
      send_column(CH_A, CH_C, CH_G, CH_G, 1'b0);
      send_column(CH_A, CH_A, CH_A, CH_C, 1'b0);
      send_column(CH_A, CH_C, CH_G, CH_T, 1'b0);
      send_column(CH_A, CH_A, CH_A, CH_A, 1'b0);
      send_column(CH_LO, CH_LO, CH_HI, CH_HI, 1'b1);
      send_column(CH_A, CH_A, CH_A, CH_A, 1'b1);

      // Two-gap skipping, ending on a skipped last column
      write_config(MODE_NUCLEOTIDE, GAP_SKIP_TWO, 1, 1);
      send_column(GAP, GAP, CH_C, CH_C, 1'b0);
      send_column(GAP, CH_A, CH_C, CH_C, 1'b0);
      send_column(GAP, GAP, GAP, GAP, 1'b1);

      // Unused gap mode keeps everything; zero weights
      write_config(MODE_NUCLEOTIDE, GAP_UNUSED, '0, '0);
      send_column(GAP, GAP, CH_C, CH_C, 1'b1);

      write_config(MODE_NUCLEOTIDE, GAP_SKIP_ANY, 5, 7);
      send_column(CH_A, GAP, CH_C, CH_C, 1'b0);
      send_column(CH_A, CH_A, CH_C, CH_C, 1'b0);
      send_column(CH_A, CH_A, GAP, CH_C, 1'b1);

      // Load every entry the protein columns can touch, then pin extremes
      foreach (protein_chars[i])
         foreach (protein_chars[j])
            send_table_write(protein_chars[i], protein_chars[j], TVW'($urandom), 1'b0);
      send_table_write(CH_A, CH_A, 8'sd127, 1'b0);
      send_table_write(CH_C, CH_C, 8'sd127, 1'b1);
      send_table_write(CH_A, CH_C, -8'sd128, 1'b0);
      send_table_write(CH_C, CH_A, -8'sd128, 1'b1);

      write_config(MODE_PROTEIN, GAP_KEEP_ALL, '1, 1);
      send_column(CH_A, CH_A, CH_C, CH_C, 1'b0);
      send_column(CH_A, CH_A, CH_C, CH_A, 1'b0);
      send_column(CH_LO, CH_HI, CH_HI, CH_LO, 1'b0);
      send_column(CH_A, CH_A, CH_C, CH_C, 1'b1);

      write_config(MODE_PROTEIN, GAP_SKIP_TWO, 3, 0);
      send_column(GAP, CH_A, CH_C, CH_C, 1'b0);
      send_column(GAP, GAP, CH_A, CH_A, 1'b1);

      target   = items_sent + RANDOM_ITEMS;
      phase_no = 0;
      while (items_sent < target) begin
         phase_no++;
         protein = 1'($urandom);
         case ($urandom_range(0, 3))
            0:       alpha = '0;
            1:       alpha = '1;
            2:       alpha = 1;
            default: alpha = ALPHA_BITS'($urandom);
         endcase
         case ($urandom_range(0, 3))
            0:       base = '0;
            1:       base = '1;
            2:       base = 1;
            default: base = BASE_BITS'($urandom);
         endcase
         write_config(score_mode_type'(protein), 2'($urandom), alpha, base);
         steady_sender = ($urandom_range(0, 3) == 0);

         // Receiver goes quiet while single-column quartets keep coming
         if (phase_no % 6 == 2) begin
            steady_sender = 1'b1;
            hold_requests++;
            repeat (16) random_column(protein, 1'b1);
         end

         quartets = $urandom_range(3, 12);
         repeat (quartets) begin
            case ($urandom_range(0, 19))
               0:                   len = $urandom_range(21, 80);
               1, 2, 3, 4, 5:       len = $urandom_range(7, 20);
               default:             len = $urandom_range(1, 6);
            endcase
            for (int k = 0; k < len; k++) begin
               if ($urandom_range(0, 9) == 0) random_table_write();
               random_column(protein, k == len - 1);
            end
         end
      end

      wait_idle();
      finish_check <= 1'b1;
      repeat (2) @(posedge clock);

      $display("Covered %0d items: %0d columns, %0d table writes, %0d register settings",
               items_sent, columns_sent, writes_sent, settings_used);
      $display("Compared %0d quartet totals, %0d long receiver hold-offs",
               totals_checked, hold_requests);
      if (fail_count == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule
